[sv/rcpd_pkg.sv]
// ----------------------------------------------------------------------------
// rcpd_pkg
// shared types and constants of the rc pulse-width channel decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rcpd_pkg;

   localparam int TIMER_BITS_DEF = 32;

   localparam int TIME_W      = 32;
   localparam int CH_W        = 2;
   localparam int AXIS_W      = 16;
   localparam int CFG_W       = 20;
   localparam int INV_W       = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int NUM_CH      = 4;
   localparam int NUM_SPAN    = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ROLL_LOW      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PITCH_LOW     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_YAW_LOW       = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STICK_HIGH    = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STICK_REST    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_LOW  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_HIGH = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_MASK   = 4'd7;

   localparam logic [CFG_W-1:0] ROLL_LOW_DEF      = 20'd89000;
   localparam logic [CFG_W-1:0] PITCH_LOW_DEF     = 20'd88000;
   localparam logic [CFG_W-1:0] YAW_LOW_DEF       = 20'd89000;
   localparam logic [CFG_W-1:0] STICK_HIGH_DEF    = 20'd152000;
   localparam logic [CFG_W-1:0] STICK_REST_DEF    = 20'd120000;
   localparam logic [CFG_W-1:0] THROTTLE_LOW_DEF  = 20'd88000;
   localparam logic [CFG_W-1:0] THROTTLE_HIGH_DEF = 20'd153000;
   localparam logic [INV_W-1:0] INVERT_MASK_DEF   = 3'd5;

   localparam logic [CH_W-1:0] CH_THROTTLE = 2'd3;

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_TICK   = 1'b1;
   localparam logic RES_VALUE   = 1'b0;
   localparam logic RES_STATUS  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [CH_W-1:0]   channel;
      logic [TIME_W-1:0] capture_time;
   } req_data_type;

   typedef struct packed {
      logic                     result_kind;
      logic [CH_W-1:0]          out_channel;
      logic signed [AXIS_W-1:0] axis_value;
      logic                     no_signal;
   } rsp_data_type;

   typedef struct packed {
      logic             start;
      logic             throttle;
      logic             invert;
      logic [CFG_W-1:0] low;
      logic [CFG_W-1:0] high;
      logic [CFG_W-1:0] rest;
   } scale_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [AXIS_W-1:0] value;
   } scale_rsp_type;

endpackage

`default_nettype wire

[sv/rcpd_scale.sv]
// ----------------------------------------------------------------------------
// rcpd_scale
// pulse width to axis value: span setup, bit-serial divide, saturation
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_scale
   import rcpd_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [TIMER_BITS-1:0] width,
   input  wire scale_req_type         scale_req,
   output scale_rsp_type              scale_rsp
);

   localparam int NUM_W  = 34;
   localparam int DEN_W  = CFG_W + 1;
   localparam int MAG_W  = NUM_W - 1;
   localparam int SHIFT  = 15;
   localparam int PROD_W = MAG_W + SHIFT;
   localparam int QUO_W  = 17;
   localparam int CNT_W  = 5;
   localparam int VAL_W  = 19;

   localparam logic [2:0] SC_IDLE = 3'd0;
   localparam logic [2:0] SC_PREP = 3'd1;
   localparam logic [2:0] SC_DIV  = 3'd2;
   localparam logic [2:0] SC_FIN  = 3'd3;

   localparam logic signed [VAL_W-1:0] V_TOP = 19'sd32767;
   localparam logic signed [VAL_W-1:0] V_BOT = -19'sd32768;
   localparam logic signed [VAL_W-1:0] V_OVF = 19'sd131072;
   localparam logic signed [VAL_W-1:0] V_ZERO = 19'sd0;
   localparam logic signed [AXIS_W-1:0] A_TOP = 16'sd32767;
   localparam logic signed [AXIS_W-1:0] A_BOT = 16'sh8000;

   logic [2:0]              state_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic signed [DEN_W-1:0] den_ff;
   logic                    thr_ff;
   logic                    inv_ff;
   logic                    above_ff;
   logic                    neg_ff;
   logic                    zero_ff;
   logic                    ovf_ff;
   logic [PROD_W-1:0]       rem_ff;
   logic [PROD_W-1:0]       dsh_ff;
   logic [QUO_W-1:0]        q_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [AXIS_W-1:0] value_ff;
   logic                    done_ff;

   logic [NUM_W-1:0]        w_ext, low_ext, rest_ext;
   logic signed [NUM_W-1:0] num_in;
   logic signed [DEN_W-1:0] den_in;
   logic                    above_in;
   logic signed [NUM_W-1:0] num_abs;
   logic signed [DEN_W-1:0] den_abs;
   logic [MAG_W-1:0]        mag;
   logic [PROD_W-1:0]       prod_in;
   logic [PROD_W:0]         diff;
   logic                    ge;
   logic signed [VAL_W-1:0] vs;
   logic signed [AXIS_W-1:0] sat;
   logic signed [AXIS_W-1:0] value_in;

   assign w_ext    = {{(NUM_W-TIMER_BITS){1'b0}}, width};
   assign low_ext  = {{(NUM_W-CFG_W){1'b0}}, scale_req.low};
   assign rest_ext = {{(NUM_W-CFG_W){1'b0}}, scale_req.rest};
   assign above_in = w_ext > rest_ext;

   always_comb begin
      if (scale_req.throttle) begin
         num_in = w_ext - low_ext;
         den_in = {1'b0, scale_req.high} - {1'b0, scale_req.low};
      end else begin
         num_in = w_ext - rest_ext;
         if (above_in) begin
            den_in = {1'b0, scale_req.high} - {1'b0, scale_req.rest};
         end else begin
            den_in = {1'b0, scale_req.low} - {1'b0, scale_req.rest};
         end
      end
   end

   // magnitudes; 32767 x = (x << 15) - x, 32768 x = x << 15
   assign num_abs = num_ff[NUM_W-1] ? -num_ff : num_ff;
   assign den_abs = den_ff[DEN_W-1] ? -den_ff : den_ff;
   assign mag     = num_abs[MAG_W-1:0];

   always_comb begin
      if (thr_ff || above_ff) begin
         prod_in = {mag, {SHIFT{1'b0}}} - {{SHIFT{1'b0}}, mag};
      end else begin
         prod_in = {mag, {SHIFT{1'b0}}};
      end
   end

   assign diff = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign ge   = !diff[PROD_W];

   always_comb begin
      if (zero_ff) begin
         if (thr_ff) begin
            vs = (num_ff > 0) ? V_TOP : V_ZERO;
         end else if (above_ff) begin
            vs = V_TOP;
         end else begin
            vs = (num_ff == 0) ? V_ZERO : V_BOT;
         end
      end else if (ovf_ff) begin
         vs = neg_ff ? -V_OVF : V_OVF;
      end else begin
         vs = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      end
      if (vs > V_TOP) begin
         sat = A_TOP;
      end else if (vs < V_BOT) begin
         sat = A_BOT;
      end else begin
         sat = vs[AXIS_W-1:0];
      end
      if (thr_ff) begin
         value_in = (vs < V_ZERO) ? '0 : sat;
      end else if (inv_ff) begin
         value_in = (sat == A_BOT) ? A_TOP : -sat;
      end else begin
         value_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= state_ff == SC_FIN;
         case (state_ff)
            SC_IDLE: begin
               if (scale_req.start) begin
                  state_ff <= SC_PREP;
               end
            end
            SC_PREP: begin
               state_ff <= (den_ff == 0) ? SC_FIN : SC_DIV;
            end
            SC_DIV: begin
               if ((cnt_ff == CNT_W'(QUO_W) && ge) || cnt_ff == '0) begin
                  state_ff <= SC_FIN;
               end
            end
            SC_FIN: begin
               state_ff <= SC_IDLE;
            end
            default: state_ff <= SC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         SC_IDLE: begin
            num_ff   <= num_in;
            den_ff   <= den_in;
            above_ff <= above_in;
            thr_ff   <= scale_req.throttle;
            inv_ff   <= scale_req.invert;
         end
         SC_PREP: begin
            rem_ff  <= prod_in;
            dsh_ff  <= {{(PROD_W-DEN_W-QUO_W){1'b0}}, den_abs, {QUO_W{1'b0}}};
            neg_ff  <= thr_ff ? (num_ff[NUM_W-1] ^ den_ff[DEN_W-1]) : den_ff[DEN_W-1];
            zero_ff <= den_ff == 0;
            ovf_ff  <= 1'b0;
            q_ff    <= '0;
            cnt_ff  <= CNT_W'(QUO_W);
         end
         SC_DIV: begin
            if (cnt_ff == CNT_W'(QUO_W) && ge) begin
               ovf_ff <= 1'b1;
            end else begin
               if (ge) begin
                  rem_ff <= diff[PROD_W-1:0];
               end
               q_ff   <= {q_ff[QUO_W-2:0], ge};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
         SC_FIN: begin
            value_ff <= value_in;
         end
         default: ;
      endcase
   end

   assign scale_rsp.done  = done_ff;
   assign scale_rsp.value = value_ff;

endmodule

`default_nettype wire

[sv/rc_pwm_channel_decoder.sv]
// ----------------------------------------------------------------------------
// rc_pwm_channel_decoder
// four-channel rc pulse-width decoder: roll, pitch, yaw, throttle
// ----------------------------------------------------------------------------
//  channel  direction  transfer
//  req_     in         edge event or signal check tick
//  rsp_     out        axis value or signal status
//  csr_     in         register write, index and data
//
//  rising edge: stored as the channel's rise time, no result
//  tick: status result, loaded into the output register from ST_OUT
//  falling edge: axis value from the bit-serial divider, via ST_START, ST_BUSY, ST_OUT
//  req_ready is low while an item is in work or its result cannot be stored
//  synchronous reset restores register defaults and channel state
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pwm_channel_decoder
   import rcpd_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_data_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_data_type                rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_BUSY  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]             state_ff;
   logic [CFG_W-1:0]       span_ff [NUM_SPAN];
   logic [INV_W-1:0]       inv_ff;
   logic [TIMER_BITS-1:0]  rise_ff [NUM_CH];
   logic [NUM_CH-1:0]      expect_ff;
   logic [NUM_CH-1:0]      seen_ff;
   logic                   lost_ff;
   logic [TIMER_BITS-1:0]  width_ff;
   logic [CH_W-1:0]        ch_ff;
   rsp_data_type           res_ff;
   logic                   rsp_valid_ff;
   rsp_data_type           rsp_data_ff;

   logic                   accept;
   logic                   lost_in;
   logic [TIMER_BITS-1:0]  t_in;
   scale_req_type          scale_req;
   scale_rsp_type          scale_rsp;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign t_in      = req_data.capture_time[TIMER_BITS-1:0];
   assign lost_in   = !(&seen_ff);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff[REG_ROLL_LOW[2:0]]      <= ROLL_LOW_DEF;
         span_ff[REG_PITCH_LOW[2:0]]     <= PITCH_LOW_DEF;
         span_ff[REG_YAW_LOW[2:0]]       <= YAW_LOW_DEF;
         span_ff[REG_STICK_HIGH[2:0]]    <= STICK_HIGH_DEF;
         span_ff[REG_STICK_REST[2:0]]    <= STICK_REST_DEF;
         span_ff[REG_THROTTLE_LOW[2:0]]  <= THROTTLE_LOW_DEF;
         span_ff[REG_THROTTLE_HIGH[2:0]] <= THROTTLE_HIGH_DEF;
         inv_ff                          <= INVERT_MASK_DEF;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROLL_LOW, REG_PITCH_LOW, REG_YAW_LOW, REG_STICK_HIGH,
            REG_STICK_REST, REG_THROTTLE_LOW, REG_THROTTLE_HIGH: begin
               span_ff[csr_index[2:0]] <= csr_data;
            end
            REG_INVERT_MASK: inv_ff <= csr_data[INV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expect_ff    <= '1;
         seen_ff      <= '0;
         lost_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            rise_ff[i] <= '0;
         end
      end else begin
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.kind == KIND_TICK) begin
                     lost_ff  <= lost_in;
                     seen_ff  <= '0;
                     state_ff <= ST_OUT;
                  end else if (expect_ff[req_data.channel]) begin
                     rise_ff[req_data.channel]   <= t_in;
                     expect_ff[req_data.channel] <= 1'b0;
                  end else begin
                     seen_ff[req_data.channel]   <= 1'b1;
                     expect_ff[req_data.channel] <= 1'b1;
                     state_ff                    <= ST_START;
                  end
               end
            end
            ST_START: state_ff <= ST_BUSY;
            ST_BUSY: begin
               if (scale_rsp.done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         width_ff <= t_in - rise_ff[req_data.channel];
         ch_ff    <= req_data.channel;
         res_ff   <= '{result_kind: RES_STATUS, out_channel: '0, axis_value: '0,
                       no_signal: lost_in};
      end
      if (state_ff == ST_BUSY && scale_rsp.done) begin
         res_ff <= '{result_kind: RES_VALUE, out_channel: ch_ff,
                     axis_value: scale_rsp.value, no_signal: lost_ff};
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_comb begin
      scale_req.start    = state_ff == ST_START;
      scale_req.throttle = ch_ff == CH_THROTTLE;
      scale_req.rest     = span_ff[REG_STICK_REST[2:0]];
      if (ch_ff == CH_THROTTLE) begin
         scale_req.invert = 1'b0;
         scale_req.low    = span_ff[REG_THROTTLE_LOW[2:0]];
         scale_req.high   = span_ff[REG_THROTTLE_HIGH[2:0]];
      end else begin
         scale_req.invert = inv_ff[ch_ff];
         scale_req.low    = span_ff[{1'b0, ch_ff}];
         scale_req.high   = span_ff[REG_STICK_HIGH[2:0]];
      end
   end

   rcpd_scale #(
      .TIMER_BITS(TIMER_BITS)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .width    (width_ff),
      .scale_req(scale_req),
      .scale_rsp(scale_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
